[hw/rtl/lss_pkg.sv]
// Package for the LIFO stack with search: operation and status codes,
// field widths and default depth. No dependencies.

package lss_pkg;

  // Field widths of the stream payload
  localparam int OP_W    = 2;
  localparam int ST_W    = 2;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 5;
  localparam int OCC_W   = 5;

  // Default stack depth
  localparam int DEPTH_DEF = 16;

  // Operation codes (code 3 leaves the stack alone and returns ST_OK)
  localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;     // capture the accepted request
    logic exec;      // run the operation against the stack
    logic pop_take;  // pick up the popped word from the memory
    logic scan;      // compare one entry, step down
    logic load;      // move the result into the output register
  } lss_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            full;
    logic            hit;       // word under compare matches
    logic            scan_end;  // word under compare is the bottom entry
    logic            out_free;  // output register can take a result
  } lss_sts_t;

endpackage

[hw/rtl/lss_ctrl.sv]
// Controller state machine of the LIFO stack with search.
// Depends on lss_pkg for the command and status structs.

module lss_ctrl
  import lss_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  lss_sts_t sts,
  output lss_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_RDWAIT = 5'b00100,
    S_SCAN   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.op == OP_POP && !sts.empty) begin
          state_nxt = S_RDWAIT;
        end else if (sts.op == OP_SEARCH && !sts.empty) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RDWAIT: begin
        cmd.pop_take = 1'b1;
        state_nxt    = S_DONE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit || sts.scan_end) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hw/rtl/lss_dpath.sv]
// Datapath of the LIFO stack with search: stack memory, fill count,
// scan pointer, result registers and output register. Depends on lss_pkg.

module lss_dpath
  import lss_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lss_cmd_t                   cmd,
  output lss_sts_t                   sts,
  input  logic signed [VALUE_W-1:0]  req_value,
  input  logic [OP_W-1:0]            req_op,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ST_W-1:0]            out_status,
  output logic signed [VALUE_W-1:0]  out_value,
  output logic [POS_W-1:0]           out_position,
  output logic [OCC_W-1:0]           out_occupancy
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(DEPTH);

  // Stack memory, bottom at entry 0
  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rd_data_r;
  logic [ADDR_W-1:0]  rd_addr;
  logic               wr_en;

  logic [CNT_W-1:0]          fill_r, fill_nxt;
  logic [ADDR_W-1:0]         scan_addr_r, scan_addr_nxt;
  logic [CNT_W-1:0]          pos_r, pos_nxt;
  logic [OP_W-1:0]           op_r, op_nxt;
  logic [VALUE_W-1:0]        val_r, val_nxt;
  logic [ST_W-1:0]           res_st_r, res_st_nxt;
  logic [VALUE_W-1:0]        res_val_r, res_val_nxt;
  logic [CNT_W-1:0]          res_pos_r, res_pos_nxt;
  logic                      out_valid_r;
  logic [ST_W-1:0]           out_st_r;
  logic [VALUE_W-1:0]        out_val_r;
  logic [POS_W-1:0]          out_pos_r;
  logic [OCC_W-1:0]          out_occ_r;
  logic                      empty, full, hit, scan_end;

  assign empty    = (fill_r == '0);
  assign full     = (fill_r == CNT_W'(DEPTH));
  assign hit      = (rd_data_r == val_r);
  assign scan_end = (scan_addr_r == '0);

  assign sts.op       = op_r;
  assign sts.empty    = empty;
  assign sts.full     = full;
  assign sts.hit      = hit;
  assign sts.scan_end = scan_end;
  assign sts.out_free = !out_valid_r || out_ready;

  // Operation execution
  always_comb begin
    fill_nxt      = fill_r;
    scan_addr_nxt = scan_addr_r;
    pos_nxt       = pos_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    res_st_nxt    = res_st_r;
    res_val_nxt   = res_val_r;
    res_pos_nxt   = res_pos_r;
    wr_en         = 1'b0;
    rd_addr       = ADDR_W'(fill_r - CNT_W'(1));

    if (cmd.latch) begin
      op_nxt  = req_op;
      val_nxt = req_value;
    end

    if (cmd.exec) begin
      res_pos_nxt = '0;
      res_st_nxt  = ST_OK;
      res_val_nxt = '0;
      unique case (op_r)
        OP_PUSH: begin
          res_val_nxt = val_r;
          if (full) begin
            res_st_nxt = ST_FULL;
          end else begin
            wr_en    = 1'b1;
            fill_nxt = fill_r + CNT_W'(1);
          end
        end
        OP_POP: begin
          if (empty) begin
            res_st_nxt = ST_EMPTY;
          end else begin
            fill_nxt = fill_r - CNT_W'(1);
          end
        end
        OP_SEARCH: begin
          res_val_nxt = val_r;
          if (empty) begin
            res_st_nxt = ST_EMPTY;
          end else begin
            scan_addr_nxt = rd_addr;
            pos_nxt       = CNT_W'(1);
          end
        end
        default: begin
          res_st_nxt = ST_OK;
        end
      endcase
    end

    // Popped word comes from the registered read, in the cycle after it
    if (cmd.pop_take) begin
      res_val_nxt = rd_data_r;
    end

    // Walk from the top down, one entry per cycle
    if (cmd.scan) begin
      if (hit) begin
        res_st_nxt  = ST_OK;
        res_pos_nxt = pos_r;
      end else if (scan_end) begin
        res_st_nxt = ST_NOTFOUND;
      end else begin
        rd_addr       = scan_addr_r - ADDR_W'(1);
        scan_addr_nxt = rd_addr;
        pos_nxt       = pos_r + CNT_W'(1);
      end
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill_r[ADDR_W-1:0]] <= val_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Payload registers
  always_ff @(posedge clk) begin
    scan_addr_r <= scan_addr_nxt;
    pos_r       <= pos_nxt;
    op_r        <= op_nxt;
    val_r       <= val_nxt;
    res_st_r    <= res_st_nxt;
    res_val_r   <= res_val_nxt;
    res_pos_r   <= res_pos_nxt;
    if (cmd.load) begin
      out_st_r  <= res_st_r;
      out_val_r <= res_val_r;
      out_pos_r <= POS_W'(res_pos_r);
      out_occ_r <= OCC_W'(fill_r);
    end
  end

  // Fill count and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_st_r;
  assign out_value     = out_val_r;
  assign out_position  = out_pos_r;
  assign out_occupancy = out_occ_r;

endmodule

[hw/rtl/lifo_stack_with_search.sv]
// Flow: the accepted request is latched and executed; a pop then waits for
// its one memory read, and a search reads one stack entry per cycle from the
// top down until a match at position k or, when none matches, the bottom
// entry. The result then waits until the output register is free.
// A new request is taken the cycle after the result enters the output register.
// Reset clears the fill count, the output valid and the controller state;
// stack contents are left as they are.

module lifo_stack_with_search
  import lss_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] result_value, [36:32] position,
                                  // [41:37] occupancy, [47:42] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  lss_cmd_t                  cmd;
  lss_sts_t                  sts;
  logic [ST_W-1:0]           res_status;
  logic signed [VALUE_W-1:0] res_value;
  logic [POS_W-1:0]          res_pos;
  logic [OCC_W-1:0]          res_occ;

  lss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lss_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .req_value     (in_tdata),
    .req_op        (in_tuser),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_status    (res_status),
    .out_value     (res_value),
    .out_position  (res_pos),
    .out_occupancy (res_occ)
  );

  assign out_tdata = {6'd0, res_occ, res_pos, res_value};
  assign out_tuser = res_status;

  // Checks
  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request taken while previous one in progress");

  a_full_empty_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(sts.full && sts.empty))
    else $error("stack flagged full and empty at once");

  a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> sts.out_free)
    else $error("result loaded over an untaken result");

  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.load))
    else $error("output valid without a result load");

endmodule
